// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL: clocked implications with an
// asynchronous active-low reset that disables checking.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/tmtw_pkg.sv -----
// ---------------------------------------------------------------------------
// tmtw_pkg
// Types and constants for the text-mode terminal writer.
// ---------------------------------------------------------------------------
package tmtw_pkg;

    localparam int DEF_SCREEN_WIDTH  = 80;
    localparam int DEF_SCREEN_HEIGHT = 25;

    localparam logic [15:0] BLANK_CELL = 16'h0F20;
    localparam logic [7:0]  ATTR_RESET = 8'h0F;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        CMD_PUT     = 2'd0,
        CMD_SET_ROW = 2'd1,
        CMD_SET_COL = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_HOLD
    } state_t;

endpackage

// ----- hw/rtl/text_mode_terminal_writer.sv -----
// ---------------------------------------------------------------------------
// text_mode_terminal_writer
// Text terminal with a cursor and a screen store of attribute/character cells.
// Input channel (in_valid/in_stall): one command transaction: put character,
// set row, set column or read cell. Output channel (out_valid/out_stall): one
// result transaction per command with the cursor, its linear index, the read
// cell (zero for non-reads) and a scroll flag.
// Config: cfg_we/cfg_data set the attribute byte used for written cells.
// Timing: an ordinary command is accepted in ST_IDLE, then does its RAM
// read-modify-write in ST_EXEC, where its result is loaded if the output is free.
// A scroll sweeps the whole cell RAM one cell per cycle (copy up one row,
// then blank the bottom row), after which its result waits in ST_HOLD.
// Reset: cursor at row 0 column 0, attribute 0x0F, no result pending. The
// cell RAM is not cleared; cells read before being written are undefined.
// Stall: a finished result sits in the output register; the next command is
// still accepted and executed, and its result waits in a hold register until
// the output register frees up.
// ---------------------------------------------------------------------------
module text_mode_terminal_writer #(
    parameter int SCREEN_WIDTH  = tmtw_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tmtw_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    // command channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  char_code,
    input  logic [7:0]  new_row,
    input  logic [7:0]  new_col,
    input  logic [10:0] cell_address,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  cursor_row,
    output logic [6:0]  cursor_col,
    output logic [10:0] cursor_index,
    output logic [15:0] cell_data,
    output logic        scrolled
);
    import tmtw_pkg::*;

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int CELL_AW    = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int ROW_W      = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int COL_W      = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int ROWX_W     = (ROW_W > 5) ? ROW_W : 5;
    localparam int COLX_W     = (COL_W > 7) ? COL_W : 7;
    localparam int IDXX_W     = (CELL_AW > 11) ? CELL_AW : 11;
    localparam int SUM_W      = CELL_AW + 9;
    localparam int COPY_COUNT = CELL_COUNT - SCREEN_WIDTH;

    // ---------------- state ----------------
    state_t               state_reg, state_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [7:0]           attr_reg;
    logic [CELL_AW-1:0]   scan_reg, scan_next;

    // latched command
    cmd_t                 cmd_reg;
    logic [7:0]           char_reg;
    logic [7:0]           nrow_reg;
    logic [7:0]           ncol_reg;
    logic                 addr_ok_reg;

    // pending result (used when the output register is busy or after a scroll)
    logic [15:0]          hold_data_reg, hold_data_next;
    logic                 hold_scrolled_reg, hold_scrolled_next;

    // output register
    logic                 out_valid_reg;
    logic [4:0]           out_row_reg;
    logic [6:0]           out_col_reg;
    logic [10:0]          out_idx_reg;
    logic [15:0]          out_data_reg;
    logic                 out_scrolled_reg;

    // ---------------- cell RAM ----------------
    logic [15:0]          mem [CELL_COUNT];
    logic                 mem_we, mem_re;
    logic [CELL_AW-1:0]   mem_waddr, mem_raddr;
    logic [15:0]          mem_wdata;
    logic [15:0]          mem_rdata_reg;

    // ---------------- helpers ----------------
    logic                 in_accept;
    logic                 out_free;
    logic                 out_load;
    logic [IDXX_W-1:0]    in_addr_ext;
    logic                 in_addr_ok;
    logic [CELL_AW-1:0]   cur_idx;
    logic                 exec_scroll;
    logic [15:0]          exec_data;
    logic [SUM_W-1:0]     scan_rd;
    logic [ROW_W-1:0]     sel_row;
    logic [COL_W-1:0]     sel_col;
    logic [CELL_AW-1:0]   sel_idx;
    logic [ROWX_W-1:0]    sel_row_ext;
    logic [COLX_W-1:0]    sel_col_ext;
    logic [IDXX_W-1:0]    sel_idx_ext;

    assign in_accept   = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign in_addr_ext = IDXX_W'(cell_address);
    assign in_addr_ok  = int'(cell_address) < CELL_COUNT;
    assign cur_idx     = CELL_AW'(row_reg) * CELL_AW'(SCREEN_WIDTH) + CELL_AW'(col_reg);
    assign scan_rd     = SUM_W'(scan_reg) + SUM_W'(SCREEN_WIDTH + 1);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_scroll)
                    state_next = ST_SCROLL;
                else if (out_free)
                    state_next = ST_IDLE;
                else
                    state_next = ST_HOLD;
            end
            ST_SCROLL:
            begin
                if (int'(scan_reg) == CELL_COUNT - 1)
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // ---------------- FSM outputs ----------------
    always_comb
    begin
        in_stall = (state_reg != ST_IDLE);
        out_load = 1'b0;
        unique case (state_reg)
            ST_EXEC:  out_load = !exec_scroll && out_free;
            ST_HOLD:  out_load = out_free;
            default:  out_load = 1'b0;
        endcase
    end

    // ---------------- command execution ----------------
    // Cursor update and the at most one RAM write of a command in ST_EXEC, and the scroll sweep writes in ST_SCROLL.
    always_comb
    begin
        row_next           = row_reg;
        col_next           = col_reg;
        exec_scroll        = 1'b0;
        exec_data          = 16'd0;
        mem_we             = 1'b0;
        mem_waddr          = cur_idx;
        mem_wdata          = {attr_reg, char_reg};
        hold_data_next     = hold_data_reg;
        hold_scrolled_next = hold_scrolled_reg;
        scan_next          = scan_reg;

        if (state_reg == ST_EXEC)
        begin
            case (cmd_reg)
                CMD_PUT:
                begin
                    if (char_reg == CH_LF)
                    begin
                        col_next = '0;
                        if (int'(row_reg) + 1 >= SCREEN_HEIGHT)
                        begin
                            exec_scroll = 1'b1;
                            row_next    = ROW_W'(SCREEN_HEIGHT - 1);
                        end
                        else
                            row_next = row_reg + ROW_W'(1);
                    end
                    else if (char_reg == CH_CR)
                    begin
                        col_next = '0;
                    end
                    else if (char_reg == CH_BS)
                    begin
                        if (col_reg != '0)
                        begin
                            col_next  = col_reg - COL_W'(1);
                            mem_we    = 1'b1;
                            mem_waddr = cur_idx - CELL_AW'(1);
                            mem_wdata = {attr_reg, CH_SPACE};
                        end
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (int'(col_reg) + 1 >= SCREEN_WIDTH)
                        begin
                            col_next = '0;
                            if (int'(row_reg) + 1 >= SCREEN_HEIGHT)
                            begin
                                exec_scroll = 1'b1;
                                row_next    = ROW_W'(SCREEN_HEIGHT - 1);
                            end
                            else
                                row_next = row_reg + ROW_W'(1);
                        end
                        else
                            col_next = col_reg + COL_W'(1);
                    end
                end
                CMD_SET_ROW:
                begin
                    if (int'(nrow_reg) >= SCREEN_HEIGHT)
                        row_next = ROW_W'(SCREEN_HEIGHT - 1);
                    else
                        row_next = ROW_W'(nrow_reg);
                end
                CMD_SET_COL:
                begin
                    if (int'(ncol_reg) >= SCREEN_WIDTH)
                        col_next = COL_W'(SCREEN_WIDTH - 1);
                    else
                        col_next = COL_W'(ncol_reg);
                end
                default:
                begin
                    if (addr_ok_reg)
                        exec_data = mem_rdata_reg;
                end
            endcase
            hold_data_next     = exec_data;
            hold_scrolled_next = exec_scroll;
            scan_next          = '0;
        end
        else if (state_reg == ST_SCROLL)
        begin
            // copy row r+1 into row r, then blank the bottom row
            mem_we    = 1'b1;
            mem_waddr = scan_reg;
            mem_wdata = (int'(scan_reg) < COPY_COUNT) ? mem_rdata_reg : BLANK_CELL;
            scan_next = scan_reg + CELL_AW'(1);
        end
    end

    // RAM read port: command read at accept, prefetch for the scroll copy
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = in_addr_ext[CELL_AW-1:0];
        if (state_reg == ST_IDLE)
        begin
            mem_re = in_accept && (cmd_t'(cmd) == CMD_READ) && in_addr_ok;
        end
        else if (state_reg == ST_EXEC)
        begin
            mem_re    = exec_scroll && (SCREEN_WIDTH < CELL_COUNT);
            mem_raddr = CELL_AW'(SCREEN_WIDTH);
        end
        else if (state_reg == ST_SCROLL)
        begin
            mem_re    = scan_rd < SUM_W'(CELL_COUNT);
            mem_raddr = scan_rd[CELL_AW-1:0];
        end
    end

    // ---------------- result selection ----------------
    assign sel_row     = (state_reg == ST_EXEC) ? row_next : row_reg;
    assign sel_col     = (state_reg == ST_EXEC) ? col_next : col_reg;
    assign sel_idx     = CELL_AW'(sel_row) * CELL_AW'(SCREEN_WIDTH) + CELL_AW'(sel_col);
    assign sel_row_ext = ROWX_W'(sel_row);
    assign sel_col_ext = COLX_W'(sel_col);
    assign sel_idx_ext = IDXX_W'(sel_idx);

    // ---------------- RAM ----------------
    // write-to-read forwarding covers a same-address access in the same cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= (mem_we && mem_waddr == mem_raddr) ? mem_wdata
                                                                : mem[mem_raddr];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            attr_reg      <= ATTR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            if (cfg_we)
                attr_reg <= cfg_data;
            out_valid_reg <= out_load || (out_valid_reg && out_stall);
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        scan_reg          <= scan_next;
        hold_data_reg     <= hold_data_next;
        hold_scrolled_reg <= hold_scrolled_next;
        if (in_accept)
        begin
            cmd_reg     <= cmd_t'(cmd);
            char_reg    <= char_code;
            nrow_reg    <= new_row;
            ncol_reg    <= new_col;
            addr_ok_reg <= in_addr_ok;
        end
        if (out_load)
        begin
            out_row_reg      <= sel_row_ext[4:0];
            out_col_reg      <= sel_col_ext[6:0];
            out_idx_reg      <= sel_idx_ext[10:0];
            out_data_reg     <= (state_reg == ST_EXEC) ? exec_data : hold_data_reg;
            out_scrolled_reg <= (state_reg == ST_EXEC) ? 1'b0 : hold_scrolled_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cursor_row   = out_row_reg;
    assign cursor_col   = out_col_reg;
    assign cursor_index = out_idx_reg;
    assign cell_data    = out_data_reg;
    assign scrolled     = out_scrolled_reg;

    // ---------------- assertions ----------------
`include "assert_macros.svh"

    `ASSERT_IMPL(a_cursor_in_bounds, clk, rst_n, 1'b1,
        (int'(row_reg) < SCREEN_HEIGHT) && (int'(col_reg) < SCREEN_WIDTH))
    `ASSERT_IMPL(a_scroll_cursor_home, clk, rst_n, state_reg == ST_SCROLL,
        (int'(row_reg) == SCREEN_HEIGHT - 1) && (col_reg == '0))
    `ASSERT_IMPL(a_no_write_on_accept, clk, rst_n, mem_we, state_reg != ST_IDLE)
    `ASSERT_NEXT(a_scroll_reports, clk, rst_n,
        (state_reg == ST_SCROLL) && (state_next == ST_HOLD), hold_scrolled_reg)

endmodule

// ----- bench/text_mode_terminal_writer_test.sv -----
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_test
// Self-checking bench for the text-mode terminal writer. A screen predictor
// tracks the cursor, the cell store and the attribute register, and works out
// the result of every accepted command transaction. A checker compares each
// result field by field with the oldest prediction. A short directed pass
// covers put, the control characters, cursor saturation, reads and scrolling.
// Random traffic then runs under several attribute settings, with bursty
// command traffic and a result side that stalls in its own pattern.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tmtw_pkg::*;

    localparam int COLS  = DEF_SCREEN_WIDTH;
    localparam int ROWS  = DEF_SCREEN_HEIGHT;
    localparam int CELLS = COLS * ROWS;

    // A scroll sweeps the whole RAM, so the random part keeps the scroll count
    // bounded to hold the run length down.
    localparam int SCROLL_BUDGET = 120;
    localparam int DRAIN_CYCLES  = CELLS + 10;
    localparam int PHASE_ITEMS   = 350;

    typedef struct packed {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [10:0] index;
        logic [15:0] data;
        logic        scrolled;
    } cursor_report_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_data = 8'h00;
    logic        in_valid = 1'b0;
    logic        in_stall;
    cmd_t        cmd = CMD_PUT;
    logic [7:0]  char_code = 8'h00;
    logic [7:0]  new_row = 8'h00;
    logic [7:0]  new_col = 8'h00;
    logic [10:0] cell_address = 11'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [10:0] cursor_index;
    logic [15:0] cell_data;
    logic        scrolled;

    text_mode_terminal_writer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .char_code    (char_code),
        .new_row      (new_row),
        .new_col      (new_col),
        .cell_address (cell_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cursor_row   (cursor_row),
        .cursor_col   (cursor_col),
        .cursor_index (cursor_index),
        .cell_data    (cell_data),
        .scrolled     (scrolled)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Screen predictor state
    // ------------------------------------------------------------------------
    logic [15:0]    screen_model [CELLS];
    bit             cell_written [CELLS];   // reads only ever target set entries
    int             model_row = 0;
    int             model_col = 0;
    logic [7:0]     model_attr = ATTR_RESET;
    int             last_written = -1;
    int             scroll_count = 0;
    int             mismatches = 0;
    cursor_report_t pending_reports [$];

    function automatic void store_cell(int idx, logic [15:0] value);
        screen_model[idx] = value;
        cell_written[idx] = 1'b1;
        last_written = idx;
    endfunction

    // Column 0 of the next row. Past the last row everything moves up one
    // row, the bottom row fills with blanks and the cursor stays on it.
    function automatic bit advance_line();
        model_col = 0;
        model_row++;
        if (model_row < ROWS)
            return 1'b0;
        for (int i = 0; i < CELLS - COLS; i++)
        begin
            screen_model[i] = screen_model[i + COLS];
            cell_written[i] = cell_written[i + COLS];
        end
        for (int i = CELLS - COLS; i < CELLS; i++)
        begin
            screen_model[i] = BLANK_CELL;
            cell_written[i] = 1'b1;
        end
        model_row = ROWS - 1;
        scroll_count++;
        return 1'b1;
    endfunction

    function automatic cursor_report_t advance_screen(cmd_t op, logic [7:0] ch,
                                                      logic [7:0] nr, logic [7:0] nc,
                                                      logic [10:0] addr);
        cursor_report_t rep;
        rep = '0;
        case (op)
            CMD_PUT:
            begin
                if (ch == CH_LF)
                    rep.scrolled = advance_line();
                else if (ch == CH_CR)
                    model_col = 0;
                else if (ch == CH_BS)
                begin
                    // backspace at column 0 leaves everything alone
                    if (model_col > 0)
                    begin
                        model_col--;
                        store_cell(model_row * COLS + model_col, {model_attr, CH_SPACE});
                    end
                end
                else
                begin
                    store_cell(model_row * COLS + model_col, {model_attr, ch});
                    model_col++;
                    if (model_col >= COLS)
                        rep.scrolled = advance_line();
                end
            end
            CMD_SET_ROW: model_row = (nr >= ROWS) ? ROWS - 1 : int'(nr);
            CMD_SET_COL: model_col = (nc >= COLS) ? COLS - 1 : int'(nc);
            default:
            begin
                // out-of-store addresses read back as zero
                if (addr < CELLS)
                    rep.data = screen_model[addr];
            end
        endcase
        rep.row   = 5'(model_row);
        rep.col   = 7'(model_col);
        rep.index = 11'(model_row * COLS + model_col);
        return rep;
    endfunction

    function automatic bit would_scroll(cmd_t op, logic [7:0] ch);
        if (op != CMD_PUT || model_row != ROWS - 1)
            return 1'b0;
        return (ch == CH_LF) || (ch != CH_CR && ch != CH_BS && model_col == COLS - 1);
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: one comparison per accepted result transaction
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cursor_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $display("%0t: result with none expected, row %0d col %0d data %h",
                         $time, cursor_row, cursor_col, cell_data);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (cursor_row !== want.row)
                begin
                    $display("%0t: cursor_row expected %0d actual %0d",
                             $time, want.row, cursor_row);
                    mismatches++;
                end
                if (cursor_col !== want.col)
                begin
                    $display("%0t: cursor_col expected %0d actual %0d",
                             $time, want.col, cursor_col);
                    mismatches++;
                end
                if (cursor_index !== want.index)
                begin
                    $display("%0t: cursor_index expected %0d actual %0d",
                             $time, want.index, cursor_index);
                    mismatches++;
                end
                if (cell_data !== want.data)
                begin
                    $display("%0t: cell_data expected %h actual %h",
                             $time, want.data, cell_data);
                    mismatches++;
                end
                if (scrolled !== want.scrolled)
                begin
                    $display("%0t: scrolled expected %0b actual %0b",
                             $time, want.scrolled, scrolled);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side stall pattern: stretches of no stall, light and heavy stall
    // ------------------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 300);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Command side. All tasks are entered and left right after a rising edge.
    // valid stays high between back-to-back transactions; it is lowered only
    // by the pause and drain tasks, which always wait on the clock before returning.
    // ------------------------------------------------------------------------
    task automatic send_command(cmd_t op, logic [7:0] ch, logic [7:0] nr,
                                logic [7:0] nc, logic [10:0] addr);
        in_valid     <= 1'b1;
        cmd          <= op;
        char_code    <= ch;
        new_row      <= nr;
        new_col      <= nc;
        cell_address <= addr;
        do
            @(posedge clk);
        while (in_stall);
        pending_reports.push_back(advance_screen(op, ch, nr, nc, addr));
    endtask

    task automatic cmd_put_char(logic [7:0] ch);
        send_command(CMD_PUT, ch, 8'($urandom), 8'($urandom), 11'($urandom));
    endtask

    task automatic cmd_set_row(logic [7:0] nr);
        send_command(CMD_SET_ROW, 8'($urandom), nr, 8'($urandom), 11'($urandom));
    endtask

    task automatic cmd_set_col(logic [7:0] nc);
        send_command(CMD_SET_COL, 8'($urandom), 8'($urandom), nc, 11'($urandom));
    endtask

    task automatic cmd_read_cell(logic [10:0] addr);
        send_command(CMD_READ, 8'($urandom), 8'($urandom), 8'($urandom), addr);
    endtask

    task automatic pause_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports.size() != 0);
    endtask

    // Attribute changes only with nothing in flight.
    task automatic write_attribute(logic [7:0] value);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        model_attr = value;
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state();
        // cursor at home, nothing written: only out-of-store reads are legal
        cmd_read_cell(11'd2047);
        cmd_read_cell(11'(CELLS));
    endtask

    task automatic test_put_and_controls();
        cmd_put_char(8'h41);
        cmd_put_char(8'h00);
        cmd_put_char(8'hFF);
        cmd_read_cell(11'd0);
        cmd_read_cell(11'd2);
        cmd_put_char(CH_CR);
        cmd_put_char(CH_BS);        // column 0: no effect
        cmd_set_col(8'd5);
        cmd_put_char(CH_BS);        // blanks column 4 with the attribute
        cmd_read_cell(11'd4);
        cmd_put_char(CH_LF);
    endtask

    task automatic test_cursor_limits();
        cmd_set_row(8'd255);
        cmd_set_row(8'd0);
        cmd_set_col(8'd255);
        cmd_put_char(8'h5A);        // last column: wraps to the next row
        cmd_read_cell(11'(COLS - 1));
        cmd_set_col(8'd0);
    endtask

    task automatic test_scroll();
        cmd_set_row(8'd200);
        cmd_set_col(8'd200);
        cmd_put_char(8'h51);        // bottom-right put scrolls
        cmd_read_cell(11'(CELLS - COLS - 1));
        cmd_read_cell(11'(CELLS - COLS));
        cmd_put_char(CH_LF);        // line feed on the last row scrolls
        cmd_read_cell(11'(CELLS - 2 * COLS - 1));
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly text runs, with control characters, cursor moves
    // and reads of cells already written or outside the store.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic(int count);
        cmd_t        op;
        logic [7:0]  ch;
        logic [7:0]  nr;
        logic [7:0]  nc;
        logic [10:0] addr;
        int unsigned pick;
        int unsigned probe;
        int          burst_left;
        burst_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                wait_drained();     // hold off until every result is back
            if (burst_left == 0)
            begin
                pause_sender($urandom_range(1, 8));
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
                                                          : $urandom_range(1, 16);
            end
            burst_left--;

            ch   = 8'($urandom);
            nr   = 8'($urandom);
            nc   = 8'($urandom);
            addr = 11'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                op   = CMD_PUT;
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    ch = CH_LF;
                else if (pick < 11)
                    ch = CH_CR;
                else if (pick < 18)
                    ch = CH_BS;
            end
            else if (pick < 70)
            begin
                op = CMD_SET_ROW;
                if ($urandom_range(0, 3) != 0)
                    nr = 8'($urandom_range(0, ROWS - 1));
            end
            else if (pick < 80)
            begin
                op = CMD_SET_COL;
                if ($urandom_range(0, 3) != 0)
                    nc = 8'($urandom_range(0, COLS - 1));
            end
            else
            begin
                op   = CMD_READ;
                addr = 11'($urandom_range(CELLS, 2047));
                pick = $urandom_range(0, 99);
                if (pick >= 15)
                begin
                    if (pick < 45 && last_written >= 0 && cell_written[last_written])
                        addr = 11'(last_written);
                    else
                    begin
                        for (int k = 0; k < 16; k++)
                        begin
                            probe = $urandom_range(0, CELLS - 1);
                            if (cell_written[probe])
                            begin
                                addr = 11'(probe);
                                break;
                            end
                        end
                    end
                end
            end

            // scroll budget spent: move off the last row instead
            if (scroll_count >= SCROLL_BUDGET && would_scroll(op, ch))
            begin
                op = CMD_SET_ROW;
                nr = 8'($urandom_range(0, ROWS - 2));
            end
            send_command(op, ch, nr, nc, addr);
        end
    endtask

    task automatic test_attribute_settings();
        test_random_traffic(PHASE_ITEMS);   // reset attribute
        write_attribute(8'h00);
        test_random_traffic(PHASE_ITEMS);
        write_attribute(8'hFF);
        test_random_traffic(PHASE_ITEMS);
        write_attribute(8'($urandom_range(1, 254)));
        test_random_traffic(PHASE_ITEMS);
        write_attribute(ATTR_RESET);
        test_random_traffic(PHASE_ITEMS);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_put_and_controls();
        test_cursor_limits();
        test_scroll();
        test_attribute_settings();

        // allow a full scroll sweep for any stray result
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("text_mode_terminal_writer_test passed");
        else
            $display("text_mode_terminal_writer_test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, scroll sweeps included.
    initial
    begin
        #10_000_000;
        $display("text_mode_terminal_writer_test failed");
        $finish;
    end

endmodule
